>>> src/dual_input_fan_delay_controller_defines.svh
// Assertion macros used by the checker file dfc_checker.sv.
// Both sample on the rising edge of clk and are quiet while rst_n is low.
`ifndef DUAL_INPUT_FAN_DELAY_CONTROLLER_DEFINES_SVH
`define DUAL_INPUT_FAN_DELAY_CONTROLLER_DEFINES_SVH

// The condition holds in the same cycle as the trigger.
`define DFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The condition holds in the cycle after the trigger.
`define DFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/dfc_pkg.sv
package dfc_pkg;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 8;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_ADDR_W-1:0] CFG_ON_DELAY_FIRST     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ON_DELAY_SECOND    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_OFF_DELAY_FIRST    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_OFF_DELAY_SECOND   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_PRESENCE_THRESHOLD = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_TICKS       = 3'd5;

  // Register reset values
  localparam logic [7:0] RST_ON_DELAY_FIRST     = 8'd40;
  localparam logic [7:0] RST_ON_DELAY_SECOND    = 8'd20;
  localparam logic [9:0] RST_OFF_DELAY_FIRST    = 10'd210;
  localparam logic [9:0] RST_OFF_DELAY_SECOND   = 10'd80;
  localparam logic [7:0] RST_PRESENCE_THRESHOLD = 8'd45;
  localparam logic [9:0] RST_WINDOW_TICKS       = 10'd1000;

  // Which input went off last
  typedef enum logic [1:0] {
    SRC_NONE   = 2'd0,
    SRC_FIRST  = 2'd1,
    SRC_SECOND = 2'd2
  } src_t;

endpackage

>>> src/dual_input_fan_delay_controller.sv
// Latency: a result appears on out_* in the cycle after its sample request is accepted.
// Throughput: one sample per cycle unless stalled; one pass of compare and increment logic
// on the window, edge and seconds counters sits between the state and the result registers.
// Reset (rst_n low, synchronous): counters and flags clear, fan off, self-power held,
// configuration registers return to their defaults, the result register empties.
module dual_input_fan_delay_controller (
  input  logic                               clk,
  input  logic                               rst_n,
  // sample requests
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dfc_pkg::IN_TDATA_W-1:0]     in_tdata,   // [0] first_level, [1] second_level,
                                                         // [2] ms_tick, [7:3] zero
  // results
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dfc_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [0] fan_on, [1] self_power,
                                                         // [2] first_present, [3] second_present,
                                                         // [7:4] zero
  // configuration writes
  input  logic                               cfg_we,
  input  logic [dfc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [dfc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import dfc_pkg::*;

  // Configuration registers
  logic [7:0]  on_dly1_r, on_dly2_r, thresh_r;
  logic [9:0]  off_dly1_r, off_dly2_r, win_ticks_r;

  // Controller state
  logic [9:0]  win_cnt_r, win_cnt_nxt;
  logic [7:0]  edges1_r, edges1_nxt, edges2_r, edges2_nxt;
  logic        prev1_r, prev1_nxt, prev2_r, prev2_nxt;
  logic        on1_r, on1_nxt, on2_r, on2_nxt;
  logic        first_after_r, first_after_nxt;
  logic [15:0] secs_r, secs_nxt;
  src_t        last_off_r, last_off_nxt;
  logic        restarted_r, restarted_nxt;
  logic        fan_r, fan_nxt;
  logic        hold_r, hold_nxt;

  // Result register
  logic                    out_valid_r;
  logic [OUT_TDATA_W-1:0]  out_data_r;

  logic        in_fire;
  logic        lvl1, lvl2, tick;
  logic [7:0]  max_on;

  // Take a new sample whenever the result register is empty or being drained.
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign lvl1   = in_tdata[0];
  assign lvl2   = in_tdata[1];
  assign tick   = in_tdata[2];
  assign max_on = (on_dly1_r > on_dly2_r) ? on_dly1_r : on_dly2_r;

  // One sample worth of state update, applied in program order.
  always_comb begin
    win_cnt_nxt     = win_cnt_r;
    edges1_nxt      = edges1_r;
    edges2_nxt      = edges2_r;
    prev1_nxt       = prev1_r;
    prev2_nxt       = prev2_r;
    on1_nxt         = on1_r;
    on2_nxt         = on2_r;
    first_after_nxt = first_after_r;
    secs_nxt        = secs_r;
    last_off_nxt    = last_off_r;
    restarted_nxt   = restarted_r;
    fan_nxt         = fan_r;
    hold_nxt        = hold_r;

    // Advance the window on a millisecond tick, saturating.
    if (tick && (win_cnt_nxt != '1)) begin
      win_cnt_nxt = win_cnt_nxt + 10'd1;
    end

    // Count rising edges, saturating.
    if (lvl1 && !prev1_nxt && (edges1_nxt != '1)) begin
      edges1_nxt = edges1_nxt + 8'd1;
    end
    prev1_nxt = lvl1;
    if (lvl2 && !prev2_nxt && (edges2_nxt != '1)) begin
      edges2_nxt = edges2_nxt + 8'd1;
    end
    prev2_nxt = lvl2;

    // Window end: judge presence, advance the seconds count.
    if (win_cnt_nxt >= win_ticks_r) begin
      win_cnt_nxt = '0;
      if (secs_nxt != '1) begin
        secs_nxt = secs_nxt + 16'd1;
      end

      if (edges1_nxt >= thresh_r) begin
        on1_nxt = 1'b1;
      end else begin
        // First input dropped while second is absent: it went off last, unless
        // it only rose after the second and never reached its on-delay.
        if (on1_nxt && !on2_nxt) begin
          last_off_nxt = SRC_FIRST;
          if (first_after_nxt && (secs_nxt < {8'b0, on_dly1_r})) begin
            last_off_nxt = SRC_SECOND;
          end
        end
        on1_nxt = 1'b0;
      end

      if (edges2_nxt >= thresh_r) begin
        on2_nxt         = 1'b1;
        first_after_nxt = 1'b0;
      end else begin
        if (on2_nxt && !on1_nxt) begin
          last_off_nxt = SRC_SECOND;
        end
        on2_nxt = 1'b0;
      end

      edges1_nxt = '0;
      edges2_nxt = '0;

      // Early power-off: nothing present, fan off, seconds below the longer on-delay.
      if (!fan_nxt && !on1_nxt && !on2_nxt && (secs_nxt < {8'b0, max_on})) begin
        hold_nxt        = 1'b0;
        win_cnt_nxt     = '0;
        secs_nxt        = '0;
        first_after_nxt = 1'b0;
        restarted_nxt   = 1'b0;
        edges1_nxt      = '0;
        edges2_nxt      = '0;
      end
    end

    // An input present: hold supply, track the first-after-second case.
    if (on1_nxt || on2_nxt) begin
      hold_nxt = 1'b1;
      if (on1_nxt && !first_after_nxt && (last_off_nxt == SRC_SECOND)) begin
        first_after_nxt = 1'b1;
        secs_nxt        = '0;
      end else if (on1_nxt && first_after_nxt && (last_off_nxt == SRC_SECOND)) begin
        first_after_nxt = 1'b0;
      end
      restarted_nxt = first_after_nxt;
      last_off_nxt  = SRC_NONE;
    end

    // Fan on after the on-delay of a present input.
    if (!fan_nxt && on1_nxt && (secs_nxt >= {8'b0, on_dly1_r})) begin
      fan_nxt = 1'b1;
    end
    if (!fan_nxt && on2_nxt && (secs_nxt >= {8'b0, on_dly2_r})) begin
      fan_nxt = 1'b1;
    end

    // Restart the seconds count once after an input goes off.
    if (((last_off_nxt == SRC_FIRST) || (last_off_nxt == SRC_SECOND)) && !restarted_nxt) begin
      secs_nxt      = '0;
      restarted_nxt = 1'b1;
    end

    // Fan off after the off-delay of the input that went off last, then power off.
    if (fan_nxt && (last_off_nxt == SRC_FIRST) && (secs_nxt >= {6'b0, off_dly1_r})) begin
      fan_nxt         = 1'b0;
      hold_nxt        = 1'b0;
      win_cnt_nxt     = '0;
      secs_nxt        = '0;
      first_after_nxt = 1'b0;
      restarted_nxt   = 1'b0;
      edges1_nxt      = '0;
      edges2_nxt      = '0;
    end
    if (fan_nxt && (last_off_nxt == SRC_SECOND) && (secs_nxt >= {6'b0, off_dly2_r})) begin
      fan_nxt         = 1'b0;
      hold_nxt        = 1'b0;
      win_cnt_nxt     = '0;
      secs_nxt        = '0;
      first_after_nxt = 1'b0;
      restarted_nxt   = 1'b0;
      edges1_nxt      = '0;
      edges2_nxt      = '0;
    end
  end

  // Configuration registers: user writes only while idle, not enforced; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_dly1_r   <= RST_ON_DELAY_FIRST;
      on_dly2_r   <= RST_ON_DELAY_SECOND;
      off_dly1_r  <= RST_OFF_DELAY_FIRST;
      off_dly2_r  <= RST_OFF_DELAY_SECOND;
      thresh_r    <= RST_PRESENCE_THRESHOLD;
      win_ticks_r <= RST_WINDOW_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ON_DELAY_FIRST:     on_dly1_r   <= cfg_wdata[7:0];
        CFG_ON_DELAY_SECOND:    on_dly2_r   <= cfg_wdata[7:0];
        CFG_OFF_DELAY_FIRST:    off_dly1_r  <= cfg_wdata;
        CFG_OFF_DELAY_SECOND:   off_dly2_r  <= cfg_wdata;
        CFG_PRESENCE_THRESHOLD: thresh_r    <= cfg_wdata[7:0];
        CFG_WINDOW_TICKS:       win_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // State advances only on an accepted sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cnt_r     <= '0;
      edges1_r      <= '0;
      edges2_r      <= '0;
      prev1_r       <= 1'b0;
      prev2_r       <= 1'b0;
      on1_r         <= 1'b0;
      on2_r         <= 1'b0;
      first_after_r <= 1'b0;
      secs_r        <= '0;
      last_off_r    <= SRC_NONE;
      restarted_r   <= 1'b0;
      fan_r         <= 1'b0;
      hold_r        <= 1'b1;
    end else if (in_fire) begin
      win_cnt_r     <= win_cnt_nxt;
      edges1_r      <= edges1_nxt;
      edges2_r      <= edges2_nxt;
      prev1_r       <= prev1_nxt;
      prev2_r       <= prev2_nxt;
      on1_r         <= on1_nxt;
      on2_r         <= on2_nxt;
      first_after_r <= first_after_nxt;
      secs_r        <= secs_nxt;
      last_off_r    <= last_off_nxt;
      restarted_r   <= restarted_nxt;
      fan_r         <= fan_nxt;
      hold_r        <= hold_nxt;
    end
  end

  // Result register: load on accept, hold while stalled, drop when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {4'b0, on2_nxt, on1_nxt, hold_nxt, fan_nxt};
    end
  end

endmodule

>>> src/dfc_checker.sv
`include "dual_input_fan_delay_controller_defines.svh"

module dfc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dfc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dfc_pkg::*;

  // A stalled result stays put.
  `DFC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // Every accepted sample shows a result in the next cycle.
  `DFC_ASSERT_NEXT(a_in_to_out, in_tvalid && in_tready, out_tvalid, "accepted sample gave no result")

  // An empty result register never blocks the input.
  `DFC_ASSERT_NOW(a_ready_empty, !out_tvalid, in_tready, "input stalled with empty result register")

  // Fan running or an input present keeps the self-power latch set.
  `DFC_ASSERT_NOW(a_power_held, out_tvalid && (out_tdata[0] || out_tdata[2] || out_tdata[3]), out_tdata[1], "self-power released while fan or input active")

endmodule

bind dual_input_fan_delay_controller dfc_checker u_dfc_checker (.*);

>>> tb/dual_input_fan_delay_controller_tb.sv
`timescale 1ns / 1ps

module dual_input_fan_delay_controller_tb;
  import dfc_pkg::*;

  // Run guard, drain length, report cap and item budget
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned TOTAL_ITEMS  = 1950;

  // Register indexes the block does not map; writes there must change nothing
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

  // How a mains-sense level moves during one stretch of random traffic
  typedef enum logic [1:0] {
    HOLD_LEVEL,
    TOGGLE_LEVEL,
    NOISE_LEVEL
  } drive_mode_t;

  // One result, bit 3 first as it sits in out_tdata
  typedef struct packed {
    logic second_present;
    logic first_present;
    logic self_power;
    logic fan_on;
  } fan_status_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // [0] first_level, [1] second_level, [2] ms_tick
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;          // [0] fan_on, [1] self_power,
                                              // [2] first_present, [3] second_present
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  // Predictor copy of the configuration
  logic [7:0]  ondly_first, ondly_second, edge_min;
  logic [9:0]  offdly_first, offdly_second, win_len;

  // Predictor copy of the controller state
  logic [9:0]  win_ticks_seen;
  logic [7:0]  rise_cnt_first, rise_cnt_second;
  logic        last_lvl_first, last_lvl_second;
  logic        pres_first, pres_second;
  logic        first_rose_late, secs_rearmed, fan_run, hold_supply;
  logic [15:0] secs;
  src_t        off_src;

  fan_status_t expected_status[$];

  int unsigned cycles;
  int unsigned items_sent;
  int unsigned random_items;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned episodes;
  bit          steady_src;    // sender never pauses while set
  bit          steady_sink;   // receiver never stalls while set
  int unsigned sink_wait;

  dual_input_fan_delay_controller DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_fan_model();
    ondly_first     = RST_ON_DELAY_FIRST;
    ondly_second    = RST_ON_DELAY_SECOND;
    offdly_first    = RST_OFF_DELAY_FIRST;
    offdly_second   = RST_OFF_DELAY_SECOND;
    edge_min        = RST_PRESENCE_THRESHOLD;
    win_len         = RST_WINDOW_TICKS;
    win_ticks_seen  = '0;
    rise_cnt_first  = '0;
    rise_cnt_second = '0;
    last_lvl_first  = 1'b0;
    last_lvl_second = 1'b0;
    pres_first      = 1'b0;
    pres_second     = 1'b0;
    first_rose_late = 1'b0;
    secs            = '0;
    off_src         = SRC_NONE;
    secs_rearmed    = 1'b0;
    fan_run         = 1'b0;
    hold_supply     = 1'b1;
  endfunction

  // Release the supply latch and clear the timing state; presence flags,
  // the last-off source and the previous levels survive.
  function automatic void cut_power();
    hold_supply     = 1'b0;
    win_ticks_seen  = '0;
    secs            = '0;
    first_rose_late = 1'b0;
    secs_rearmed    = 1'b0;
    rise_cnt_first  = '0;
    rise_cnt_second = '0;
  endfunction

  function automatic fan_status_t step_fan_model(logic lvl_a, logic lvl_b, logic tick);
    logic [7:0]  longest_on;
    fan_status_t res;
    // tick advances the window, saturating
    if (tick && win_ticks_seen != 10'd1023) win_ticks_seen++;
    // count rising edges, saturating
    if (lvl_a && !last_lvl_first && rise_cnt_first != 8'd255) rise_cnt_first++;
    last_lvl_first = lvl_a;
    if (lvl_b && !last_lvl_second && rise_cnt_second != 8'd255) rise_cnt_second++;
    last_lvl_second = lvl_b;

    // window end: judge presence, advance seconds, maybe power off early
    if (win_ticks_seen >= win_len) begin
      longest_on = (ondly_first > ondly_second) ? ondly_first : ondly_second;
      win_ticks_seen = '0;
      if (secs != 16'hFFFF) secs++;
      if (rise_cnt_first >= edge_min) begin
        pres_first = 1'b1;
      end else begin
        if (pres_first && !pres_second) begin
          off_src = SRC_FIRST;
          // first came back after the second but never made its on-delay
          if (first_rose_late && secs < ondly_first) off_src = SRC_SECOND;
        end
        pres_first = 1'b0;
      end
      if (rise_cnt_second >= edge_min) begin
        pres_second     = 1'b1;
        first_rose_late = 1'b0;
      end else begin
        if (pres_second && !pres_first) off_src = SRC_SECOND;
        pres_second = 1'b0;
      end
      rise_cnt_first  = '0;
      rise_cnt_second = '0;
      if (!fan_run && !pres_first && !pres_second && secs < longest_on) cut_power();
    end

    // presence holds the supply and may restart the seconds count
    if (pres_first || pres_second) begin
      hold_supply = 1'b1;
      if (pres_first && !first_rose_late && off_src == SRC_SECOND) begin
        first_rose_late = 1'b1;
        secs            = '0;
      end else if (pres_first && first_rose_late && off_src == SRC_SECOND) begin
        first_rose_late = 1'b0;
      end
      secs_rearmed = first_rose_late;
      off_src      = SRC_NONE;
    end

    if (!fan_run && pres_first && secs >= ondly_first) fan_run = 1'b1;
    if (!fan_run && pres_second && secs >= ondly_second) fan_run = 1'b1;

    // start the off-delay count once per source going off
    if ((off_src == SRC_FIRST || off_src == SRC_SECOND) && !secs_rearmed) begin
      secs         = '0;
      secs_rearmed = 1'b1;
    end

    if (fan_run && off_src == SRC_FIRST && secs >= offdly_first) begin
      fan_run = 1'b0;
      cut_power();
    end
    if (fan_run && off_src == SRC_SECOND && secs >= offdly_second) begin
      fan_run = 1'b0;
      cut_power();
    end

    res.fan_on         = fan_run;
    res.self_power     = hold_supply;
    res.first_present  = pres_first;
    res.second_present = pres_second;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: all sampling happens on pre-edge values
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : monitor
    fan_status_t want;
    fan_status_t got;
    if (!rst_n) begin
      reset_fan_model();
      expected_status.delete();
    end else begin
      // mirror configuration writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ON_DELAY_FIRST:     ondly_first   = cfg_wdata[7:0];
          CFG_ON_DELAY_SECOND:    ondly_second  = cfg_wdata[7:0];
          CFG_OFF_DELAY_FIRST:    offdly_first  = cfg_wdata;
          CFG_OFF_DELAY_SECOND:   offdly_second = cfg_wdata;
          CFG_PRESENCE_THRESHOLD: edge_min      = cfg_wdata[7:0];
          CFG_WINDOW_TICKS:       win_len       = cfg_wdata;
          default: ;
        endcase
      end
      // predict every accepted sample request
      if (in_tvalid && in_tready)
        expected_status.push_back(step_fan_model(in_tdata[0], in_tdata[1], in_tdata[2]));
      // compare every accepted result with the oldest prediction
      if (out_tvalid && out_tready) begin
        got = fan_status_t'(out_tdata[3:0]);
        if (expected_status.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] result with nothing expected: tdata=%h", $realtime, out_tdata);
        end else begin
          want = expected_status.pop_front();
          results_checked++;
          if (got.fan_on !== want.fan_on || got.self_power !== want.self_power ||
              got.first_present !== want.first_present ||
              got.second_present !== want.second_present ||
              out_tdata[OUT_TDATA_W-1:4] !== '0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("[%0t] result %0d: fan/pwr/p1/p2 expected %b%b%b%b got %b%b%b%b pad=%h",
                       $realtime, results_checked, want.fan_on, want.self_power,
                       want.first_present, want.second_present, got.fan_on,
                       got.self_power, got.first_present, got.second_present,
                       out_tdata[OUT_TDATA_W-1:4]);
          end
        end
      end
    end
  end

  // Receiver: after each accepted result, stall for a random number of cycles unless steady_sink is set
  always @(posedge clk) begin : sink_ctrl
    int unsigned stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_wait  <= 0;
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      if (sink_wait == 1) out_tready <= 1'b1;
    end else if (out_tready && out_tvalid) begin
      stall = steady_sink ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_tready <= 1'b0;
        sink_wait  <= stall;
      end
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks
  // ---------------------------------------------------------------------------

  // Send one sample request; hold it until the block takes it.
  task automatic send_sample(input logic lvl_a, input logic lvl_b, input logic tick);
    int unsigned gap;
    gap = steady_src ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-3){1'b0}}, tick, lvl_b, lvl_a};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Drop valid, let every expected result come back, then settle for the drain length.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all six registers, one per cycle; only call while idle.
  task automatic apply_settings(input logic [7:0] on_a, input logic [7:0] on_b,
                                input logic [9:0] off_a, input logic [9:0] off_b,
                                input logic [7:0] thr, input logic [9:0] win);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_ON_DELAY_FIRST;
    cfg_wdata <= CFG_DATA_W'(on_a);
    @(posedge clk);
    cfg_addr  <= CFG_ON_DELAY_SECOND;
    cfg_wdata <= CFG_DATA_W'(on_b);
    @(posedge clk);
    cfg_addr  <= CFG_OFF_DELAY_FIRST;
    cfg_wdata <= off_a;
    @(posedge clk);
    cfg_addr  <= CFG_OFF_DELAY_SECOND;
    cfg_wdata <= off_b;
    @(posedge clk);
    cfg_addr  <= CFG_PRESENCE_THRESHOLD;
    cfg_wdata <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_addr  <= CFG_WINDOW_TICKS;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic drive_mode_t pick_mode();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return TOGGLE_LEVEL;
    if (roll < 85) return HOLD_LEVEL;
    return NOISE_LEVEL;
  endfunction

  function automatic logic next_level(drive_mode_t mode, logic cur);
    case (mode)
      TOGGLE_LEVEL: return ~cur;
      NOISE_LEVEL:  return logic'($urandom_range(0, 1));
      default:      return cur;
    endcase
  endfunction

  // Mostly small values so windows close and delays run out; now and then an extreme.
  function automatic logic [9:0] pick_setting(input int unsigned typical_max,
                                              input int unsigned full_max);
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(0, 1) ? 10'(full_max) : 10'd0;
    return 10'($urandom_range(0, typical_max));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default registers straight out of reset: every field at both values.
  task automatic test_reset_defaults();
    steady_src  = 1'b0;
    steady_sink = 1'b0;
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b1, 1'b1);
    send_sample(1'b0, 1'b0, 1'b1);
    send_sample(1'b1, 1'b0, 1'b0);
    send_sample(1'b0, 1'b1, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0);
    wait_idle();
  endtask

  // A zero window length closes a window on every sample.
  task automatic test_zero_window();
    steady_src  = 1'b1;
    steady_sink = 1'b0;
    // threshold zero: both inputs count present at once, fan on with no delay
    apply_settings(8'd0, 8'd0, 10'd0, 10'd0, 8'd0, 10'd0);
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b1, 1'b0, 1'b1);
    send_sample(1'b0, 1'b1, 1'b0);
    wait_idle();
    // threshold one, inputs rise then go quiet: both drop out, fan off and power-off reset
    apply_settings(8'd0, 8'd0, 10'd0, 10'd0, 8'd1, 10'd0);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b0, 1'b0, 1'b1);
    send_sample(1'b0, 1'b0, 1'b0);
    wait_idle();
  endtask

  // Second input present and gone, then the first one rises.
  task automatic test_first_after_second();
    steady_src  = 1'b0;
    steady_sink = 1'b1;
    apply_settings(8'd2, 8'd1, 10'd3, 10'd2, 8'd1, 10'd1);
    send_sample(1'b0, 1'b1, 1'b1);
    send_sample(1'b0, 1'b0, 1'b1);
    send_sample(1'b0, 1'b1, 1'b1);
    send_sample(1'b0, 1'b0, 1'b1);
    send_sample(1'b1, 1'b0, 1'b1);
    send_sample(1'b0, 1'b0, 1'b1);
    send_sample(1'b1, 1'b0, 1'b1);
    send_sample(1'b0, 1'b0, 1'b1);
    wait_idle();
  endtask

  // Writes to unmapped indexes must leave every register alone.
  task automatic test_unmapped_index();
    apply_settings(8'd1, 8'd1, 10'd2, 10'd2, 8'd2, 10'd2);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SPARE_LO;
    cfg_wdata <= '0;
    @(posedge clk);
    cfg_addr  <= CFG_SPARE_HI;
    cfg_wdata <= '1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    send_sample(1'b1, 1'b0, 1'b1);
    send_sample(1'b0, 1'b1, 1'b1);
    wait_idle();
  endtask

  // Every register at its top value.
  task automatic test_register_extremes();
    apply_settings(8'd255, 8'd255, 10'd1023, 10'd1023, 8'd255, 10'd1023);
    send_sample(1'b1, 1'b1, 1'b1);
    send_sample(1'b0, 1'b0, 1'b1);
    wait_idle();
  endtask

  // Over 255 rises of both levels within one window: the rise counters must stick at 255.
  task automatic test_edge_saturation();
    logic lvl;
    steady_src  = 1'b1;
    steady_sink = ($urandom_range(0, 1) == 1);
    apply_settings(8'd0, 8'd0, 10'd1, 10'd1, 8'd255, 10'd1);
    lvl = 1'b0;
    repeat (520) begin
      lvl = ~lvl;
      send_sample(lvl, lvl, 1'b0);
    end
    // close the window, then let both inputs go quiet
    send_sample(1'b0, 1'b0, 1'b1);
    repeat (4) send_sample(1'b0, 1'b0, 1'b1);
    wait_idle();
  endtask

  // Random episodes: fresh registers, then stretches of toggling, held and noisy levels.
  task automatic test_random_traffic(input int unsigned target);
    int unsigned first_item;
    int unsigned seg_len;
    int unsigned tick_pct;
    drive_mode_t mode_a, mode_b;
    logic        lvl_a, lvl_b, tick;
    first_item = items_sent;
    lvl_a = 1'b0;
    lvl_b = 1'b0;
    while (items_sent - first_item < target) begin
      wait_idle();
      apply_settings(8'(pick_setting(6, 255)), 8'(pick_setting(6, 255)),
                     pick_setting(12, 1023), pick_setting(12, 1023),
                     8'(pick_setting(3, 255)), pick_setting(4, 1023));
      steady_src  = ($urandom_range(0, 3) == 0);
      steady_sink = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 10)) begin
        seg_len  = $urandom_range(4, 40);
        mode_a   = pick_mode();
        mode_b   = pick_mode();
        case ($urandom_range(0, 2))
          0:       tick_pct = 100;
          1:       tick_pct = 50;
          default: tick_pct = 10;
        endcase
        repeat (seg_len) begin
          // stop at the item budget, even inside an episode
          if (items_sent - first_item < target) begin
            lvl_a = next_level(mode_a, lvl_a);
            lvl_b = next_level(mode_b, lvl_b);
            tick  = ($urandom_range(1, 100) <= tick_pct);
            send_sample(lvl_a, lvl_b, tick);
          end
        end
      end
      episodes++;
    end
    wait_idle();
    random_items = items_sent - first_item;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    cycles          = 0;
    items_sent      = 0;
    random_items    = 0;
    results_checked = 0;
    mismatches      = 0;
    episodes        = 0;
    steady_src      = 1'b0;
    steady_sink     = 1'b0;
    sink_wait       = 0;
    reset_fan_model();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_zero_window();
    test_first_after_second();
    test_unmapped_index();
    test_register_extremes();
    test_edge_saturation();
    test_random_traffic((items_sent < TOTAL_ITEMS) ? TOTAL_ITEMS - items_sent : 0);

    $display("Sent %0d samples, %0d of them under %0d random register settings; %0d checked.",
             items_sent, random_items, episodes, results_checked);
    $display("Covered zero-length windows, saturated edge counts, unmapped writes; %0d bad.",
             mismatches);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> dual_input_fan_delay_controller.f
+incdir+src
src/dfc_pkg.sv
src/dual_input_fan_delay_controller.sv
src/dfc_checker.sv
tb/dual_input_fan_delay_controller_tb.sv
